@@ rtl/gtq_pkg.sv @@
// gtq_pkg: shared types and constants of the grouped team queue.
// Used by gtq_front, gtq_back and grouped_team_queue; depends on nothing.
`default_nettype none
package gtq_pkg;

   localparam int ELEMENT_SPACE_DEF = 1024;
   localparam int TEAMS_DEF = 16;
   localparam int NODES_DEF = 256;
   localparam int FRONT_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_ASSIGN  = 2'd0,
      KIND_ENQUEUE = 2'd1,
      KIND_DEQUEUE = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   typedef struct packed {
      kind_type    kind;
      logic [9:0]  element;
      logic [3:0]  team;
   } item_type;

endpackage
`default_nettype wire

@@ rtl/grouped_team_queue.sv @@
// grouped_team_queue: team queue with an element-to-team map.
// Instantiates gtq_front and gtq_back; depends on gtq_pkg.
//
// Request beats (req_*) carry one of four kinds: assign element to team,
// enqueue, dequeue, clear all. Every request gives exactly one response
// beat (rsp_*) in request order. A two-entry queue in front of the
// sequencer takes requests while the sequencer works or waits on rsp_ready.
// Sequencer steps: assign and dequeue on empty end in the idle state;
//   enqueue reads the map (rejects end there), writes the node and, if its
//   team waits, links it to the tail; dequeue reads order, head/tail, node.
// Response appears in the cycle after the sequencer finishes and is held
// in an output register until taken; a new item starts only when that
// register is free or being drained, so a stalled receiver stalls the
// sequencer and then the front queue, which drops req_ready when full.
// Reset and clear all sweep the map, one map entry a cycle, req_ready low.
`default_nettype none
module grouped_team_queue #(
   parameter int ELEMENT_SPACE = gtq_pkg::ELEMENT_SPACE_DEF,
   parameter int TEAMS = gtq_pkg::TEAMS_DEF,
   parameter int NODES = gtq_pkg::NODES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [9:0]  req_element,
   input  wire logic [3:0]  req_team,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [9:0]       rsp_element_out,
   output logic [3:0]       rsp_team_out,
   output logic [1:0]       rsp_status
);

   logic              item_valid;
   logic              item_pop;
   logic              sweeping;
   gtq_pkg::item_type item;

   gtq_front u_front (
      .clock, .reset, .hold(sweeping),
      .req_valid, .req_ready, .req_kind, .req_element, .req_team,
      .item_valid, .item, .item_pop);

   gtq_back #(
      .ELEMENT_SPACE(ELEMENT_SPACE), .TEAMS(TEAMS), .NODES(NODES)
   ) u_back (
      .clock, .reset, .item_valid, .item, .item_pop, .sweeping,
      .rsp_valid, .rsp_ready, .rsp_element_out, .rsp_team_out, .rsp_status);

endmodule
`default_nettype wire

@@ rtl/gtq_ram.sv @@
// gtq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/gtq_front.sv @@
// gtq_front: accepts request beats, decodes the kind and queues items.
// Depends on gtq_pkg.
`default_nettype none
module gtq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              hold,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   input  wire logic [9:0]        req_element,
   input  wire logic [3:0]        req_team,
   output logic                   item_valid,
   output gtq_pkg::item_type      item,
   input  wire logic              item_pop
);

   localparam int PW = $clog2(gtq_pkg::FRONT_DEPTH);

   gtq_pkg::item_type slot_ff [gtq_pkg::FRONT_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff, fill_in;
   logic          push;
   gtq_pkg::item_type incoming;

   always_comb begin
      incoming.kind    = gtq_pkg::kind_type'(req_kind);
      incoming.element = req_element;
      incoming.team    = req_team;
      req_ready  = !hold && (fill_ff != (PW+1)'(gtq_pkg::FRONT_DEPTH));
      push       = req_valid && req_ready;
      item_valid = fill_ff != '0;
      item       = slot_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(gtq_pkg::FRONT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(gtq_pkg::FRONT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + (PW+1)'(push) - (PW+1)'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/gtq_back.sv @@
// gtq_back: sequencer that carries out queued items on the team map,
// the linked-list node pool and the team order. Depends on gtq_pkg, gtq_ram.
`default_nettype none
module gtq_back #(
   parameter int ELEMENT_SPACE = gtq_pkg::ELEMENT_SPACE_DEF,
   parameter int TEAMS = gtq_pkg::TEAMS_DEF,
   parameter int NODES = gtq_pkg::NODES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire gtq_pkg::item_type item,
   output logic                   item_pop,
   output logic                   sweeping,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [9:0]             rsp_element_out,
   output logic [3:0]             rsp_team_out,
   output logic [1:0]             rsp_status
);

   localparam int EW = $clog2(ELEMENT_SPACE);
   localparam int TW = $clog2(TEAMS);
   localparam int NW = $clog2(NODES);

   typedef enum logic [2:0] {
      S_SWEEP, S_IDLE, S_EMAP, S_ENODE, S_ELINK, S_DORD, S_DHEAD, S_DNODE
   } state_type;

   state_type         state_ff, state_in;
   gtq_pkg::item_type item_ff, item_in;
   logic [TW-1:0]     t_ff, t_in;
   logic [NW-1:0]     node_ff, node_in, tail_ff, tail_in;
   logic [TEAMS-1:0]  waiting_ff, waiting_in;
   logic [TW-1:0]     front_ff, front_in;
   logic [TW:0]       count_ff, count_in;
   logic [NW:0]       fc_ff, fc_in, min_ff, min_in;
   logic [EW-1:0]     sweep_ff, sweep_in;
   logic              reply_ff, reply_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [9:0]        rsp_elem_ff, rsp_elem_in;
   logic [3:0]        rsp_team_ff, rsp_team_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic              map_we;
   logic [EW-1:0]     map_wa, map_ra;
   logic [TW:0]       map_wd, map_rd;
   logic              head_we, tail_we, order_we;
   logic [TW-1:0]     team_ra, order_wa;
   logic [NW-1:0]     head_wd, tail_wd, head_rd, tail_rd;
   logic [TW-1:0]     order_wd, order_rd;
   logic              value_we, next_we, free_we;
   logic [NW-1:0]     value_wa, next_wa, next_wd, next_rd, free_wa, free_wd, free_rd;
   logic [NW-1:0]     free_ra;
   logic [9:0]        value_wd, value_rd;
   logic [NW:0]       fc_dec;
   logic [NW-1:0]     node_pick;
   logic [TW+1:0]     pos_sum;
   logic              elem_ok;

   gtq_ram #(.WIDTH(TW + 1), .DEPTH(ELEMENT_SPACE)) u_map (
      .clock, .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd));
   gtq_ram #(.WIDTH(NW), .DEPTH(TEAMS)) u_head (
      .clock, .wr_en(head_we), .wr_addr(t_ff), .wr_data(head_wd),
      .rd_addr(team_ra), .rd_data(head_rd));
   gtq_ram #(.WIDTH(NW), .DEPTH(TEAMS)) u_tail (
      .clock, .wr_en(tail_we), .wr_addr(t_ff), .wr_data(tail_wd),
      .rd_addr(team_ra), .rd_data(tail_rd));
   gtq_ram #(.WIDTH(TW), .DEPTH(TEAMS)) u_order (
      .clock, .wr_en(order_we), .wr_addr(order_wa), .wr_data(order_wd),
      .rd_addr(front_ff), .rd_data(order_rd));
   gtq_ram #(.WIDTH(10), .DEPTH(NODES)) u_value (
      .clock, .wr_en(value_we), .wr_addr(value_wa), .wr_data(value_wd),
      .rd_addr(head_rd), .rd_data(value_rd));
   gtq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
      .clock, .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(head_rd), .rd_data(next_rd));
   gtq_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
      .clock, .wr_en(free_we), .wr_addr(free_wa), .wr_data(free_wd),
      .rd_addr(free_ra), .rd_data(free_rd));

   assign sweeping        = state_ff == S_SWEEP;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_element_out = rsp_elem_ff;
   assign rsp_team_out    = rsp_team_ff;
   assign rsp_status      = rsp_status_ff;

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      t_in       = t_ff;
      node_in    = node_ff;
      tail_in    = tail_ff;
      waiting_in = waiting_ff;
      front_in   = front_ff;
      count_in   = count_ff;
      fc_in      = fc_ff;
      min_in     = min_ff;
      sweep_in   = sweep_ff;
      reply_in   = reply_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_elem_in   = rsp_elem_ff;
      rsp_team_in   = rsp_team_ff;
      rsp_status_in = rsp_status_ff;
      item_pop = 1'b0;

      map_we = 1'b0;
      map_wa = EW'(item.element);
      map_wd = '0;
      map_ra = EW'(item.element);
      team_ra  = (state_ff == S_DORD) ? order_rd : map_rd[TW-1:0];
      head_we  = 1'b0;
      tail_we  = 1'b0;
      head_wd  = node_ff;
      tail_wd  = node_ff;
      order_we = 1'b0;
      pos_sum  = (TW+2)'(front_ff) + (TW+2)'(count_ff);
      order_wa = (pos_sum >= (TW+2)'(TEAMS)) ? TW'(pos_sum - (TW+2)'(TEAMS)) : TW'(pos_sum);
      order_wd = t_ff;
      fc_dec   = fc_ff - 1'b1;
      free_ra  = fc_dec[NW-1:0];
      node_pick = (fc_ff == min_ff) ? fc_dec[NW-1:0] : free_rd;
      value_we = 1'b0;
      value_wa = node_pick;
      value_wd = item_ff.element;
      next_we  = 1'b0;
      next_wa  = node_pick;
      next_wd  = '0;
      free_we  = 1'b0;
      free_wa  = fc_ff[NW-1:0];
      free_wd  = node_ff;
      elem_ok  = 32'(item_ff.element) < 32'(ELEMENT_SPACE);

      case (state_ff)
         S_SWEEP: begin
            map_we = 1'b1;
            map_wa = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == EW'(ELEMENT_SPACE - 1)) begin
               state_in = S_IDLE;
               if (reply_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_elem_in   = '0;
                  rsp_team_in   = '0;
                  rsp_status_in = gtq_pkg::STATUS_OK;
               end
            end
         end
         S_IDLE: begin
            if (item_valid && (!rsp_valid_ff || rsp_ready)) begin
               item_pop = 1'b1;
               item_in  = item;
               case (item.kind)
                  gtq_pkg::KIND_ASSIGN: begin
                     map_we = (32'(item.element) < 32'(ELEMENT_SPACE))
                              && (32'(item.team) < 32'(TEAMS));
                     map_wd = {1'b1, TW'(item.team)};
                     rsp_valid_in  = 1'b1;
                     rsp_elem_in   = '0;
                     rsp_team_in   = '0;
                     rsp_status_in = gtq_pkg::STATUS_OK;
                  end
                  gtq_pkg::KIND_ENQUEUE: begin
                     state_in = S_EMAP;
                  end
                  gtq_pkg::KIND_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_elem_in   = '0;
                        rsp_team_in   = '0;
                        rsp_status_in = gtq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = S_DORD;
                     end
                  end
                  gtq_pkg::KIND_CLEAR: begin
                     waiting_in = '0;
                     front_in   = '0;
                     count_in   = '0;
                     fc_in      = (NW+1)'(NODES);
                     min_in     = (NW+1)'(NODES);
                     sweep_in   = '0;
                     reply_in   = 1'b1;
                     state_in   = S_SWEEP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_EMAP: begin
            state_in = S_IDLE;
            t_in = map_rd[TW-1:0];
            rsp_valid_in = 1'b1;
            rsp_elem_in  = '0;
            if (!elem_ok || !map_rd[TW]) begin
               rsp_team_in   = '0;
               rsp_status_in = gtq_pkg::STATUS_UNMAPPED;
            end else if (fc_ff == '0) begin
               rsp_team_in   = 4'(map_rd[TW-1:0]);
               rsp_status_in = gtq_pkg::STATUS_FULL;
            end else begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
               state_in = S_ENODE;
            end
         end
         S_ENODE: begin
            value_we = 1'b1;
            next_we  = 1'b1;
            node_in  = node_pick;
            tail_in  = tail_rd;
            fc_in    = fc_dec;
            min_in   = (fc_dec < min_ff) ? fc_dec : min_ff;
            if (waiting_ff[t_ff]) begin
               state_in = S_ELINK;
            end else begin
               head_we = 1'b1;
               tail_we = 1'b1;
               head_wd = node_pick;
               tail_wd = node_pick;
               waiting_in[t_ff] = 1'b1;
               if (count_ff < (TW+1)'(TEAMS)) begin
                  order_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = '0;
               rsp_team_in   = 4'(t_ff);
               rsp_status_in = gtq_pkg::STATUS_OK;
            end
         end
         S_ELINK: begin
            next_we = 1'b1;
            next_wa = tail_ff;
            next_wd = node_ff;
            tail_we = 1'b1;
            state_in = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_elem_in   = '0;
            rsp_team_in   = 4'(t_ff);
            rsp_status_in = gtq_pkg::STATUS_OK;
         end
         S_DORD: begin
            t_in = order_rd;
            state_in = S_DHEAD;
         end
         S_DHEAD: begin
            node_in = head_rd;
            tail_in = tail_rd;
            state_in = S_DNODE;
         end
         S_DNODE: begin
            if (node_ff == tail_ff) begin
               waiting_in[t_ff] = 1'b0;
               front_in = (front_ff == TW'(TEAMS - 1)) ? '0 : front_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               head_we = 1'b1;
               head_wd = next_rd;
            end
            if (fc_ff < (NW+1)'(NODES)) begin
               free_we = 1'b1;
               fc_in   = fc_ff + 1'b1;
            end
            state_in = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_elem_in   = value_rd;
            rsp_team_in   = 4'(t_ff);
            rsp_status_in = gtq_pkg::STATUS_OK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      t_ff          <= t_in;
      node_ff       <= node_in;
      tail_ff       <= tail_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_team_ff   <= rsp_team_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_SWEEP;
         waiting_ff   <= '0;
         front_ff     <= '0;
         count_ff     <= '0;
         fc_ff        <= (NW+1)'(NODES);
         min_ff       <= (NW+1)'(NODES);
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         waiting_ff   <= waiting_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         fc_ff        <= fc_in;
         min_ff       <= min_in;
         sweep_ff     <= sweep_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire
